>>> design/ecdf_independence_statistic_defines.svh
// Assertion macros shared by the ECDF independence statistic RTL
`ifndef ECDF_INDEPENDENCE_STATISTIC_DEFINES_SVH
`define ECDF_INDEPENDENCE_STATISTIC_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ECDF_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ECDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ecdf_pkg.sv
// Shared constants and types of the ECDF independence statistic
package ecdf_pkg;

    localparam int MAX_PAIRS_DEF = 1024;
    localparam int SAMPLE_W      = 32;
    localparam int STAT_W        = 22;
    localparam int FRAC_SHIFT    = 32;

    localparam logic [SAMPLE_W-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic              done;
        logic [STAT_W-1:0] value;
    } stat_resp_t;

endpackage

>>> design/ecdf_if.sv
// Stream interfaces of the sample pair and result channels
interface ecdf_pair_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ecdf_pkg::SAMPLE_W-1:0] x_sample;
    logic signed [ecdf_pkg::SAMPLE_W-1:0] y_sample;
    logic                                 last_pair;

    modport source (output valid, x_sample, y_sample, last_pair, input ready);
    modport sink   (input valid, x_sample, y_sample, last_pair, output ready);
endinterface

interface ecdf_result_if #(
    parameter int NW = 11,
    parameter int DW = 21
);
    logic                          valid;
    logic                          ready;
    logic [DW-1:0]                 max_deviation;
    logic [NW-1:0]                 pair_count;
    logic [ecdf_pkg::STAT_W-1:0]   statistic;

    modport source (output valid, max_deviation, pair_count, statistic, input ready);
    modport sink   (input valid, max_deviation, pair_count, statistic, output ready);
endinterface

>>> design/ecdf_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port
module ecdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/ecdf_stat.sv
// Serial unit for D / n^1.5 in Q6.16: restoring divide, then digit square root
module ecdf_stat #(
    parameter int NW = 11,
    parameter int DW = 21
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DW-1:0]        dev,
    input  logic [NW-1:0]        n,
    output ecdf_pkg::stat_resp_t resp
);

    localparam int SW   = ecdf_pkg::STAT_W;
    localparam int N3W  = 3 * NW;
    localparam int NUMW = 2 * DW + ecdf_pkg::FRAC_SHIFT;
    localparam int SQW  = 2 * SW;
    localparam int QW   = (NUMW > SQW + 1) ? NUMW : SQW + 1;
    localparam int CW   = $clog2(NUMW + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_N2   = 7'b0000010,
        S_N3   = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_SQ0  = 7'b0010000,
        S_SQRT = 7'b0100000,
        S_DONE = 7'b1000000
    } stat_state_t;

    stat_state_t       state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DW-1:0]     d_reg, d_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [2*DW-1:0]   sq_reg, sq_next;
    logic [N3W-1:0]    n3_reg, n3_next;
    logic [NUMW-1:0]   num_reg, num_next;
    logic [N3W-1:0]    rem_reg, rem_next;
    logic [NUMW-1:0]   q_reg, q_next;
    logic [SQW-1:0]    v_reg, v_next;
    logic [SW-1:0]     root_reg, root_next;
    logic [SW+1:0]     srem_reg, srem_next;
    logic              sat_reg, sat_next;

    logic [N3W:0]      rem_sh;
    logic              q_bit;
    logic [QW-1:0]     q_ext;
    logic [SW+3:0]     rem2;
    logic [SW+3:0]     trial;

    always_comb
    begin
        rem_sh = {rem_reg, num_reg[NUMW-1]};
        q_bit  = (rem_sh >= {1'b0, n3_reg});
        q_ext  = QW'(q_reg);
        rem2   = {srem_reg, v_reg[SQW-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        d_next     = d_reg;
        n_next     = n_reg;
        sq_next    = sq_reg;
        n3_next    = n3_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        v_next     = v_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        sat_next   = sat_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    d_next     = dev;
                    n_next     = n;
                    state_next = S_N2;
                end
            end
            S_N2:
            begin
                n3_next    = N3W'(n_reg * n_reg);
                sq_next    = (2*DW)'(d_reg * d_reg);
                state_next = S_N3;
            end
            S_N3:
            begin
                n3_next    = N3W'(n3_reg[2*NW-1:0] * n_reg);
                num_next   = {sq_reg, {ecdf_pkg::FRAC_SHIFT{1'b0}}};
                rem_next   = '0;
                q_next     = '0;
                cnt_next   = CW'(NUMW);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = q_bit ? N3W'(rem_sh - {1'b0, n3_reg}) : rem_sh[N3W-1:0];
                q_next   = {q_reg[NUMW-2:0], q_bit};
                num_next = {num_reg[NUMW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = S_SQ0;
                end
            end
            S_SQ0:
            begin
                v_next     = q_ext[SQW-1:0];
                sat_next   = |q_ext[QW-1:SQW];
                root_next  = '0;
                srem_next  = '0;
                cnt_next   = CW'(SW);
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (rem2 >= trial)
                begin
                    srem_next = (SW+2)'(rem2 - trial);
                    root_next = {root_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    srem_next = rem2[SW+1:0];
                    root_next = {root_reg[SW-2:0], 1'b0};
                end
                v_next   = {v_reg[SQW-3:0], 2'b00};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_next;
        n_reg    <= n_next;
        sq_reg   <= sq_next;
        n3_reg   <= n3_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        v_reg    <= v_next;
        root_reg <= root_next;
        srem_reg <= srem_next;
        sat_reg  <= sat_next;
    end

    assign resp.done  = (state_reg == S_DONE);
    assign resp.value = sat_reg ? {SW{1'b1}} : root_reg;

endmodule

>>> design/ecdf_independence_statistic.sv
// Top level of the ECDF independence statistic: load, rank, sweep, scale
// Loading takes one pair transfer per cycle. After the last pair the block ranks,
// sweeps and scales, ranking and sweeping through each store's single read port,
// with the pair channel held off meanwhile.
// The result register frees the pair channel while a result waits for transfer.
// rst_n (async, active low) clears the sequencer, pair count, maximum and valid.
`include "ecdf_independence_statistic_defines.svh"

module ecdf_independence_statistic #(
    parameter int MAX_PAIRS = ecdf_pkg::MAX_PAIRS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    ecdf_pair_if.sink         pairs,
    ecdf_result_if.source     result
);

    localparam int AW = $clog2(MAX_PAIRS);
    localparam int NW = AW + 1;
    localparam int DW = 2 * AW + 1;
    localparam int XW = ecdf_pkg::SAMPLE_W;

    // Sequencer: load, then rank (count smaller keys), then the prefix sweep, then scale and output
    typedef enum logic [13:0] {
        LOAD    = 14'h0001,
        RK_LD   = 14'h0002,
        RK_LDW  = 14'h0004,
        RK_RD   = 14'h0008,
        RK_CMP  = 14'h0010,
        RK_WR   = 14'h0020,
        SW_ROW  = 14'h0040,
        SW_ROWW = 14'h0080,
        SW_ORD  = 14'h0100,
        SW_YRD  = 14'h0200,
        SW_ACC  = 14'h0400,
        ST_GO   = 14'h0800,
        ST_WAIT = 14'h1000,
        ST_OUT  = 14'h2000
    } seq_state_t;

    seq_state_t    state_reg, state_next;
    logic [NW-1:0] n_reg, n_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] m_reg, m_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] rx_reg, rx_next;
    logic [AW-1:0] ry_reg, ry_next;
    logic [XW-1:0] xk_reg, xk_next;
    logic [XW-1:0] yk_reg, yk_next;
    logic [XW-1:0] yt_reg, yt_next;
    logic [DW-1:0] a_reg, a_next;
    logic [DW-1:0] b_reg, b_next;
    logic [DW-1:0] max_reg, max_next;
    logic [ecdf_pkg::STAT_W-1:0] stat_reg, stat_next;
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_dev_reg, out_dev_next;
    logic [NW-1:0] out_n_reg, out_n_next;
    logic [ecdf_pkg::STAT_W-1:0] out_stat_reg, out_stat_next;

    // store ports
    logic          load_we;
    logic [AW-1:0] x_raddr, y_raddr;
    logic [XW-1:0] x_rd, y_rd, ys_rd;
    logic [AW-1:0] xo_rd;
    logic          rank_we;

    ecdf_pkg::stat_resp_t stat_resp;

    // datapath helpers
    logic          pair_xfer;
    logic          x_less, y_less;
    logic          y_le;
    logic [DW-1:0] a_new, b_new, dev_new;
    logic          out_free;
    logic          k_last, m_last, j_last, i_last;

    assign pair_xfer = pairs.valid && pairs.ready;
    assign pairs.ready = (state_reg == LOAD);
    assign load_we = pair_xfer;
    assign rank_we = (state_reg == RK_WR);

    assign x_raddr = (state_reg == RK_LD) ? k_reg : m_reg;
    assign y_raddr = (state_reg == RK_LD) ? k_reg :
                     (state_reg == SW_YRD) ? xo_rd : m_reg;

    // samples kept in offset binary so unsigned compare orders signed values
    ecdf_ram #(.WIDTH(XW), .DEPTH(MAX_PAIRS)) u_x_store (
        .clk   (clk),
        .we    (load_we),
        .waddr (n_reg[AW-1:0]),
        .wdata (pairs.x_sample ^ ecdf_pkg::SIGN_FLIP),
        .raddr (x_raddr),
        .rdata (x_rd)
    );

    ecdf_ram #(.WIDTH(XW), .DEPTH(MAX_PAIRS)) u_y_store (
        .clk   (clk),
        .we    (load_we),
        .waddr (n_reg[AW-1:0]),
        .wdata (pairs.y_sample ^ ecdf_pkg::SIGN_FLIP),
        .raddr (y_raddr),
        .rdata (y_rd)
    );

    // x_order[rank] = index, written once per pair during ranking
    ecdf_ram #(.WIDTH(AW), .DEPTH(MAX_PAIRS)) u_x_order (
        .clk   (clk),
        .we    (rank_we),
        .waddr (rx_reg),
        .wdata (k_reg),
        .raddr (j_reg),
        .rdata (xo_rd)
    );

    ecdf_ram #(.WIDTH(XW), .DEPTH(MAX_PAIRS)) u_y_sorted (
        .clk   (clk),
        .we    (rank_we),
        .waddr (ry_reg),
        .wdata (yk_reg),
        .raddr (i_reg),
        .rdata (ys_rd)
    );

    ecdf_stat #(.NW(NW), .DW(DW)) u_stat (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_GO),
        .dev   (max_reg),
        .n     (n_reg),
        .resp  (stat_resp)
    );

    // stable rank: smaller key, or equal key that arrived earlier
    assign x_less = (x_rd < xk_reg) || ((x_rd == xk_reg) && (m_reg < k_reg));
    assign y_less = (y_rd < yk_reg) || ((y_rd == yk_reg) && (m_reg < k_reg));

    // incremental n*count and (i+1)*(j+1)
    assign y_le    = (y_rd <= yt_reg);
    assign a_new   = a_reg + (y_le ? DW'(n_reg) : '0);
    assign b_new   = b_reg + DW'(i_reg) + DW'(1);
    assign dev_new = (a_new > b_new) ? (a_new - b_new) : (b_new - a_new);

    assign k_last = ({1'b0, k_reg} == n_reg - NW'(1));
    assign m_last = ({1'b0, m_reg} == n_reg - NW'(1));
    assign j_last = ({1'b0, j_reg} == n_reg - NW'(2));
    assign i_last = ({1'b0, i_reg} == n_reg - NW'(2));

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        m_next        = m_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        rx_next       = rx_reg;
        ry_next       = ry_reg;
        xk_next       = xk_reg;
        yk_next       = yk_reg;
        yt_next       = yt_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        max_next      = max_reg;
        stat_next     = stat_reg;
        out_dev_next  = out_dev_reg;
        out_n_next    = out_n_reg;
        out_stat_next = out_stat_reg;
        out_valid_next = (out_valid_reg && !result.ready);
        unique case (state_reg)
            LOAD:
            begin
                if (pair_xfer)
                begin
                    n_next = n_reg + NW'(1);
                    // a full store closes the set as a last pair would
                    if (pairs.last_pair || (n_reg == NW'(MAX_PAIRS - 1)))
                    begin
                        k_next     = '0;
                        state_next = RK_LD;
                    end
                end
            end
            RK_LD:
            begin
                state_next = RK_LDW;
            end
            RK_LDW:
            begin
                xk_next    = x_rd;
                yk_next    = y_rd;
                m_next     = '0;
                rx_next    = '0;
                ry_next    = '0;
                state_next = RK_RD;
            end
            RK_RD:
            begin
                state_next = RK_CMP;
            end
            RK_CMP:
            begin
                rx_next = rx_reg + AW'(x_less);
                ry_next = ry_reg + AW'(y_less);
                m_next  = m_reg + AW'(1);
                state_next = m_last ? RK_WR : RK_RD;
            end
            RK_WR:
            begin
                k_next = k_reg + AW'(1);
                if (k_last)
                begin
                    i_next     = '0;
                    max_next   = '0;
                    state_next = (n_reg < NW'(2)) ? ST_GO : SW_ROW;
                end
                else
                begin
                    state_next = RK_LD;
                end
            end
            SW_ROW:
            begin
                state_next = SW_ROWW;
            end
            SW_ROWW:
            begin
                yt_next    = ys_rd;
                j_next     = '0;
                a_next     = '0;
                b_next     = '0;
                state_next = SW_ORD;
            end
            SW_ORD:
            begin
                state_next = SW_YRD;
            end
            SW_YRD:
            begin
                state_next = SW_ACC;
            end
            SW_ACC:
            begin
                a_next = a_new;
                b_next = b_new;
                if (dev_new > max_reg)
                begin
                    max_next = dev_new;
                end
                j_next = j_reg + AW'(1);
                if (j_last)
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = i_last ? ST_GO : SW_ROW;
                end
                else
                begin
                    state_next = SW_ORD;
                end
            end
            ST_GO:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (stat_resp.done)
                begin
                    stat_next  = stat_resp.value;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_dev_next   = max_reg;
                    out_n_next     = n_reg;
                    out_stat_next  = stat_reg;
                    out_valid_next = 1'b1;
                    n_next         = '0;
                    max_next       = '0;
                    state_next     = LOAD;
                end
            end
            default:
            begin
                state_next = LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= LOAD;
            n_reg         <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        m_reg        <= m_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        xk_reg       <= xk_next;
        yk_reg       <= yk_next;
        yt_reg       <= yt_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        stat_reg     <= stat_next;
        out_dev_reg  <= out_dev_next;
        out_n_reg    <= out_n_next;
        out_stat_reg <= out_stat_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.max_deviation = out_dev_reg;
    assign result.pair_count    = out_n_reg;
    assign result.statistic     = out_stat_reg;

    `ECDF_ASSERT(a_count_bound, 1'b1, n_reg <= NW'(MAX_PAIRS), "pair count above store depth")
    `ECDF_ASSERT(a_stat_done, stat_resp.done, state_reg == ST_WAIT, "scaler done outside wait")
    `ECDF_ASSERT(a_sweep_row, (state_reg == SW_ACC), {1'b0, i_reg} < n_reg - NW'(1),
        "sweep row past n-1")
    `ECDF_ASSERT_NEXT(a_result_load, (state_reg == ST_OUT) && out_free,
        out_valid_reg && (state_reg == LOAD) && (n_reg == '0), "result not posted")

endmodule
